>>> hdl/sync_framed_reading_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// sync_framed_reading_receiver_top_macros.svh
// Assertion macros shared by the receiver modules.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_READING_RECEIVER_TOP_MACROS_SVH
`define SYNC_FRAMED_READING_RECEIVER_TOP_MACROS_SVH

// same-cycle implication
`define SFRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sfrr_pkg.sv
// ----------------------------------------------------------------------------
// sfrr_pkg
// Types and constants of the sync framed reading receiver.
// ----------------------------------------------------------------------------
package sfrr_pkg;

  localparam int BYTE_W   = 8;
  localparam int MV_W     = 16;
  localparam int DIGIT_W  = 7;
  localparam int BAR_W    = 7;
  localparam int STAT_W   = 2;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 16;

  // config register indexes
  localparam logic [CFG_A_W-1:0] CFG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_FULL_SCALE  = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_BAR_FULL    = 3'd3;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;
  localparam logic [MV_W-1:0]   FULL_SCALE_RST  = 16'd3300;
  localparam logic [BAR_W-1:0]  BAR_FULL_RST    = 7'd124;
  localparam logic [MV_W-1:0]   LAST_GOOD_RST   = 16'hFFFF;

  // reading status codes
  localparam logic [STAT_W-1:0] RD_NEW       = 2'd0;
  localparam logic [STAT_W-1:0] RD_CKSUM_ERR = 2'd1;
  localparam logic [STAT_W-1:0] RD_RANGE     = 2'd2;
  localparam logic [STAT_W-1:0] RD_SAME      = 2'd3;

  // mv / 1000 = (mv * 67109) >> 26, exact for 16-bit mv
  localparam int RECIP_KILO_W = 17;
  localparam logic [RECIP_KILO_W-1:0] RECIP_KILO = 17'd67109;
  localparam int KILO_SHIFT = 26;
  localparam int PV_W = MV_W + RECIP_KILO_W;
  localparam logic [9:0] KILO = 10'd1000;
  localparam int REM_W = 10;

  // rem / 10 = (rem * 6554) >> 16, exact for rem < 1000
  localparam int RECIP_TEN_W = 13;
  localparam logic [RECIP_TEN_W-1:0] RECIP_TEN = 13'd6554;
  localparam int TEN_SHIFT = 16;
  localparam int HP_W = REM_W + RECIP_TEN_W;

  // bar divider: quotient below 2**BAR_W when mv <= full scale
  localparam int NUM_W = MV_W + BAR_W;
  localparam int DEN_W = MV_W + BAR_W - 1;
  localparam int DIV_STEPS = BAR_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_HUNT1,
    ST_HUNT2,
    ST_HIGH,
    ST_LOW,
    ST_CKSUM,
    ST_CALC,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic cap_hi;
    logic cap_lo;
    logic cap_ck;
    logic calc_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic match_first;
    logic match_second;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/sfrr_in_if.sv
// ----------------------------------------------------------------------------
// sfrr_in_if
// Received byte channel, valid/ready.
// ----------------------------------------------------------------------------
interface sfrr_in_if
  import sfrr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hdl/sfrr_out_if.sv
// ----------------------------------------------------------------------------
// sfrr_out_if
// Decoded reading channel, valid/ready.
// ----------------------------------------------------------------------------
interface sfrr_out_if
  import sfrr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [MV_W-1:0]    millivolts;
  logic [DIGIT_W-1:0] volts_digit;
  logic [DIGIT_W-1:0] hundredths;
  logic [BAR_W-1:0]   bar_width;

  modport source (output valid, output status, output millivolts, output volts_digit,
                  output hundredths, output bar_width, input ready);
  modport sink (input valid, input status, input millivolts, input volts_digit,
                input hundredths, input bar_width, output ready);
endinterface

>>> hdl/sfrr_ctrl.sv
// ----------------------------------------------------------------------------
// sfrr_ctrl
// Frame hunt and decode sequencer.
// ----------------------------------------------------------------------------
`include "sync_framed_reading_receiver_top_macros.svh"

module sfrr_ctrl
  import sfrr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT1;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_HUNT1: begin
        if (in_fire && sts.match_first) state_nxt = ST_HUNT2;
      end
      ST_HUNT2: begin
        if (in_fire) begin
          if (sts.match_second)     state_nxt = ST_HIGH;
          else if (!sts.match_first) state_nxt = ST_HUNT1;
        end
      end
      ST_HIGH: begin
        if (in_fire) state_nxt = ST_LOW;
      end
      ST_LOW: begin
        if (in_fire) state_nxt = ST_CKSUM;
      end
      ST_CKSUM: begin
        if (in_fire) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_DIV;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_LOAD;
        else             cnt_nxt   = cnt_r - 1'b1;
      end
      ST_LOAD: begin
        if (sts.out_free) state_nxt = ST_HUNT1;
      end
      default: state_nxt = ST_HUNT1;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_HUNT1, ST_HUNT2: in_ready = 1'b1;
      ST_HIGH: begin
        in_ready   = 1'b1;
        cmd.cap_hi = in_valid;
      end
      ST_LOW: begin
        in_ready   = 1'b1;
        cmd.cap_lo = in_valid;
      end
      ST_CKSUM: begin
        in_ready   = 1'b1;
        cmd.cap_ck = in_valid;
      end
      ST_CALC: cmd.calc_start = 1'b1;
      ST_DIV:  cmd.div_step   = 1'b1;
      ST_LOAD: cmd.load_out   = sts.out_free;
      default: in_ready = 1'b0;
    endcase
  end

  `SFRR_ASSERT_NEXT(a_ck_to_calc, cmd.cap_ck, cmd.calc_start, "checksum word not followed by calc")
  `SFRR_ASSERT_NEXT(a_calc_to_div, cmd.calc_start, cmd.div_step, "calc not followed by divide")
  `SFRR_ASSERT_NEXT(a_load_to_hunt, cmd.load_out, in_ready && !cmd.div_step, "no return to hunt")

endmodule

>>> hdl/sfrr_datapath.sv
// ----------------------------------------------------------------------------
// sfrr_datapath
// Config registers, frame bytes, checksum/range check, digit pipeline,
// bar divider and result register.
// ----------------------------------------------------------------------------
`include "sync_framed_reading_receiver_top_macros.svh"

module sfrr_datapath
  import sfrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [MV_W-1:0]    out_millivolts,
  output logic [DIGIT_W-1:0] out_volts_digit,
  output logic [DIGIT_W-1:0] out_hundredths,
  output logic [BAR_W-1:0]   out_bar_width
);

  logic [BYTE_W-1:0]  sync1_r, sync2_r;
  logic [MV_W-1:0]    fs_r;
  logic [BAR_W-1:0]   bfw_r;
  logic [BYTE_W-1:0]  hi_r, lo_r, ck_r;
  logic [MV_W-1:0]    last_good_r;
  logic [PV_W-1:0]    pv_r;
  logic [DIGIT_W-1:0] volts_r;
  logic [REM_W-1:0]   rem_r;
  logic [HP_W-1:0]    hp_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [BAR_W-1:0]   quo_r;
  logic [STAT_W-1:0]  stat_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [MV_W-1:0]    out_mv_r;
  logic [DIGIT_W-1:0] out_volts_r, out_hund_r;
  logic [BAR_W-1:0]   out_bar_r;

  logic [MV_W-1:0]    mv;
  logic [BYTE_W-1:0]  expect_ck;
  logic [STAT_W-1:0]  stat_calc;
  logic [NUM_W-1:0]   den_ext;
  logic               div_ge;
  logic               digits_ok, bar_ok;

  assign mv        = {hi_r, lo_r};
  assign expect_ck = sync1_r ^ sync2_r ^ hi_r ^ lo_r;
  assign den_ext   = NUM_W'(den_r);
  assign div_ge    = num_r >= den_ext;
  assign digits_ok = stat_r != RD_CKSUM_ERR;
  assign bar_ok    = (stat_r == RD_NEW || stat_r == RD_SAME) && (fs_r != '0);

  always_comb begin
    if (expect_ck != ck_r)     stat_calc = RD_CKSUM_ERR;
    else if (mv > fs_r)        stat_calc = RD_RANGE;
    else if (mv == last_good_r) stat_calc = RD_SAME;
    else                       stat_calc = RD_NEW;
  end

  assign sts.match_first  = in_rx_byte == sync1_r;
  assign sts.match_second = in_rx_byte == sync2_r;
  assign sts.out_free     = !out_valid_r || out_ready;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r <= SYNC_FIRST_RST;
      sync2_r <= SYNC_SECOND_RST;
      fs_r    <= FULL_SCALE_RST;
      bfw_r   <= BAR_FULL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SYNC_FIRST:  sync1_r <= cfg_wdata[BYTE_W-1:0];
        CFG_SYNC_SECOND: sync2_r <= cfg_wdata[BYTE_W-1:0];
        CFG_FULL_SCALE:  fs_r    <= cfg_wdata[MV_W-1:0];
        CFG_BAR_FULL:    bfw_r   <= cfg_wdata[BAR_W-1:0];
        default: ;
      endcase
    end
  end

  // frame bytes
  always_ff @(posedge clk) begin
    if (cmd.cap_hi) hi_r <= in_rx_byte;
    if (cmd.cap_lo) lo_r <= in_rx_byte;
    if (cmd.cap_ck) ck_r <= in_rx_byte;
  end

  // digit pipeline: volts_r, rem_r and hp_r registered in turn from pv_r
  always_ff @(posedge clk) begin
    volts_r <= pv_r[KILO_SHIFT +: DIGIT_W];
    rem_r   <= REM_W'(MV_W'(mv) - MV_W'(volts_r) * MV_W'(KILO));
    hp_r    <= HP_W'(rem_r) * HP_W'(RECIP_TEN);
  end

  // product setup and restoring bar divider
  always_ff @(posedge clk) begin
    if (cmd.calc_start) begin
      pv_r   <= PV_W'(mv) * PV_W'(RECIP_KILO);
      num_r  <= NUM_W'(mv) * NUM_W'(bfw_r);
      den_r  <= {fs_r, (BAR_W-1)'(0)};
      quo_r  <= '0;
      stat_r <= stat_calc;
    end else if (cmd.div_step) begin
      if (div_ge) num_r <= num_r - den_ext;
      quo_r <= {quo_r[BAR_W-2:0], div_ge};
      den_r <= den_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_good_r <= LAST_GOOD_RST;
    end else if (cmd.load_out && stat_r == RD_NEW) begin
      last_good_r <= mv;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= stat_r;
      out_mv_r     <= digits_ok ? mv : '0;
      out_volts_r  <= digits_ok ? volts_r : '0;
      out_hund_r   <= digits_ok ? hp_r[TEN_SHIFT +: DIGIT_W] : '0;
      out_bar_r    <= bar_ok ? quo_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_millivolts  = out_mv_r;
  assign out_volts_digit = out_volts_r;
  assign out_hundredths  = out_hund_r;
  assign out_bar_width   = out_bar_r;

  `SFRR_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid_r, "loaded result not valid")
  `SFRR_ASSERT_NOW(a_bar_status, out_valid_r && out_bar_r != '0, out_status_r == RD_NEW || out_status_r == RD_SAME, "bar on a rejected reading")
  `SFRR_ASSERT_NEXT(a_good_update, cmd.load_out && stat_r == RD_NEW, last_good_r == $past(mv), "last good value not updated")

endmodule

>>> hdl/sync_framed_reading_receiver_top.sv
// ----------------------------------------------------------------------------
// sync_framed_reading_receiver_top
// Two-byte sync frame deframer with XOR checksum, decoding millivolt
// readings into digits and a scaled bar width.
//
//   channel  dir  handshake       payload
//   in_if    in   valid/ready     rx_byte
//   out_if   out  valid/ready     status, millivolts, volts_digit,
//                                 hundredths, bar_width
//   cfg_*    in   cfg_we          cfg_addr, cfg_wdata
//
// Each byte before the checksum word is taken while in_ready is high.
// After the checksum word in_ready drops while the checksum, range and
// product setup is done, the one-bit-per-cycle bar divider runs and the
// result register is loaded. The result register holds while out_ready is
// low; input then stalls only once a further reading is waiting to load.
// rst_n is synchronous; it restores config defaults and the hunt state.
// ----------------------------------------------------------------------------
module sync_framed_reading_receiver_top
  import sfrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  sfrr_in_if.sink            in_if,
  sfrr_out_if.source         out_if,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_if.ready = in_ready;

  sfrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfrr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_rx_byte      (in_if.rx_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_status      (out_if.status),
    .out_millivolts  (out_if.millivolts),
    .out_volts_digit (out_if.volts_digit),
    .out_hundredths  (out_if.hundredths),
    .out_bar_width   (out_if.bar_width)
  );

endmodule

>>> verif/sfrr_reading_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfrr_reading_checker
// Watches the byte, reading and register ports of the receiver, keeps its
// own deframer state, predicts each decoded reading and compares it, field
// by field, with what the block delivers.
// ----------------------------------------------------------------------------
module sfrr_reading_checker
  import sfrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  sfrr_in_if                 in_mon,
  sfrr_out_if                out_mon,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  output int                 mismatches,
  output int                 pending
);

  localparam int MV_PER_VOLT      = 1000;
  localparam int MV_PER_HUNDREDTH = 10;
  localparam int REPORT_LIMIT     = 10;

  typedef enum logic [1:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    TAKE_BODY
  } seek_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [MV_W-1:0]    mv;
    logic [DIGIT_W-1:0] volts;
    logic [DIGIT_W-1:0] hund;
    logic [BAR_W-1:0]   bar;
  } reading_t;

  logic [BYTE_W-1:0] sync_a;
  logic [BYTE_W-1:0] sync_b;
  logic [MV_W-1:0]   scale;
  logic [BAR_W-1:0]  bar_full;

  seek_t             seek;
  logic [1:0]        body_cnt;
  logic [BYTE_W-1:0] val_hi;
  logic [BYTE_W-1:0] val_lo;
  logic [MV_W-1:0]   last_good;

  reading_t readings_due[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic reading_t grade_frame(input logic [BYTE_W-1:0] ck);
    reading_t          r;
    logic [MV_W-1:0]   mv;
    logic [BYTE_W-1:0] want;
    r    = '0;
    mv   = {val_hi, val_lo};
    want = sync_a ^ sync_b ^ val_hi ^ val_lo;
    if (want != ck) begin
      r.status = RD_CKSUM_ERR;
    end else begin
      r.mv    = mv;
      r.volts = DIGIT_W'(int'(mv) / MV_PER_VOLT);
      r.hund  = DIGIT_W'((int'(mv) % MV_PER_VOLT) / MV_PER_HUNDREDTH);
      if (mv > scale) begin
        r.status = RD_RANGE;
      end else begin
        r.status = (mv == last_good) ? RD_SAME : RD_NEW;
        if (scale != '0) r.bar = BAR_W'((32'(mv) * 32'(bar_full)) / 32'(scale));
      end
    end
    return r;
  endfunction

  task automatic flag(input string why, input reading_t e, input reading_t a);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t %s: exp st=%0d mv=%0d v=%0d h=%0d bar=%0d act st=%0d mv=%0d v=%0d h=%0d bar=%0d",
               $realtime, why, e.status, e.mv, e.volts, e.hund, e.bar,
               a.status, a.mv, a.volts, a.hund, a.bar);
    end
  endtask

  always @(posedge clk) begin
    reading_t          act;
    reading_t          exp_r;
    logic [BYTE_W-1:0] b;
    if (!rst_n) begin
      sync_a    = SYNC_FIRST_RST;
      sync_b    = SYNC_SECOND_RST;
      scale     = FULL_SCALE_RST;
      bar_full  = BAR_FULL_RST;
      seek      = SEEK_FIRST;
      body_cnt  = '0;
      val_hi    = '0;
      val_lo    = '0;
      last_good = LAST_GOOD_RST;
      readings_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        act = '{out_mon.status, out_mon.millivolts, out_mon.volts_digit,
                out_mon.hundredths, out_mon.bar_width};
        if (readings_due.size() == 0) begin
          flag("unexpected reading", '0, act);
        end else begin
          exp_r = readings_due.pop_front();
          if (exp_r.status !== act.status || exp_r.mv !== act.mv ||
              exp_r.volts !== act.volts || exp_r.hund !== act.hund ||
              exp_r.bar !== act.bar) begin
            flag("reading mismatch", exp_r, act);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        b = in_mon.rx_byte;
        case (seek)
          SEEK_SECOND: begin
            if (b == sync_b) begin
              body_cnt = '0;
              seek     = TAKE_BODY;
            end else if (b != sync_a) begin
              seek = SEEK_FIRST;
            end
          end
          TAKE_BODY: begin
            if (body_cnt == 2'd0) begin
              val_hi   = b;
              body_cnt = 2'd1;
            end else if (body_cnt == 2'd1) begin
              val_lo   = b;
              body_cnt = 2'd2;
            end else begin
              seek     = SEEK_FIRST;
              body_cnt = '0;
              exp_r    = grade_frame(b);
              if (exp_r.status == RD_NEW) last_good = exp_r.mv;
              readings_due.push_back(exp_r);
            end
          end
          default: begin
            seek = (b == sync_a) ? SEEK_SECOND : SEEK_FIRST;
          end
        endcase
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SYNC_FIRST:  sync_a   = cfg_wdata[BYTE_W-1:0];
          CFG_SYNC_SECOND: sync_b   = cfg_wdata[BYTE_W-1:0];
          CFG_FULL_SCALE:  scale    = cfg_wdata[MV_W-1:0];
          CFG_BAR_FULL:    bar_full = cfg_wdata[BAR_W-1:0];
          default: ;
        endcase
      end
    end
    pending = readings_due.size();
  end

endmodule

>>> verif/sync_framed_reading_receiver_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_framed_reading_receiver_top_tb
// Drives received bytes into the deframer: a directed set of frames for
// the reset settings, a checksum with sync registers changed mid-frame,
// then phases of mostly well-formed frames mixed with noise and broken
// frames under several register settings. Both sides stall at random;
// the reading side also holds off for a long stretch once. A checker
// module predicts and compares every reading.
// ----------------------------------------------------------------------------
module sync_framed_reading_receiver_top_tb;
  import sfrr_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_WORDS     = 40;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_PHASES   = 5;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [CFG_D_W-1:0] cfg_wdata;

  sfrr_in_if  in_if ();
  sfrr_out_if out_if ();

  int mismatches;
  int pending;

  logic [BYTE_W-1:0] sync_a;
  logic [BYTE_W-1:0] sync_b;
  logic [MV_W-1:0]   scale;
  logic [BAR_W-1:0]  bar_full;
  logic [MV_W-1:0]   last_mv;
  int                words_sent;
  bit                calm;
  bit                hold_req;

  sync_framed_reading_receiver_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  sfrr_reading_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("sync_framed_reading_receiver_top_tb NOT OK");
    $finish;
  end

  // reading side: random stalls, one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_frame(input logic [MV_W-1:0] mv, input bit bad_ck, input int reps);
    logic [BYTE_W-1:0] ck;
    ck = sync_a ^ sync_b ^ mv[15:8] ^ mv[7:0];
    if (bad_ck) ck = ck ^ BYTE_W'($urandom_range(1, 255));
    send_word(sync_a);
    repeat (reps) send_word(sync_a);
    send_word(sync_b);
    send_word(mv[15:8]);
    send_word(mv[7:0]);
    send_word(ck);
    last_mv = mv;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [BYTE_W-1:0] sa, input logic [BYTE_W-1:0] sb,
                              input logic [MV_W-1:0] fs, input logic [BAR_W-1:0] bw);
    set_reg(CFG_SYNC_FIRST, {8'($urandom), sa});
    set_reg(CFG_SYNC_SECOND, {8'($urandom), sb});
    set_reg(CFG_FULL_SCALE, fs);
    set_reg(CFG_BAR_FULL, {9'($urandom), bw});
    if ($urandom_range(0, 1) == 0)
      set_reg(CFG_BAR_FULL + CFG_A_W'($urandom_range(1, 4)), 16'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
    sync_a   = sa;
    sync_b   = sb;
    scale    = fs;
    bar_full = bw;
  endtask

  function automatic logic [MV_W-1:0] pick_reading();
    case ($urandom_range(0, 9))
      0, 1:    return last_mv;
      2:       return '0;
      3:       return scale;
      4:       return scale + 1'b1;
      5:       return '1;
      6:       return MV_W'($urandom);
      default: return (scale == '0) ? '0 : MV_W'($urandom_range(0, scale));
    endcase
  endfunction

  task automatic run_phase(input int words);
    int start;
    int n;
    start = words_sent;
    while (words_sent - start < words) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 3);
          repeat (n) send_word(BYTE_W'($urandom));
        end
        1: begin
          send_word(sync_a);
          send_word(sync_b);
          n = $urandom_range(0, 2);
          repeat (n) send_word(BYTE_W'($urandom));
        end
        default: begin
          send_frame(pick_reading(), $urandom_range(0, 7) == 0,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
        end
      endcase
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] sa;
    logic [BYTE_W-1:0] sb;
    logic [MV_W-1:0]   fs;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    words_sent    = 0;
    sync_a        = SYNC_FIRST_RST;
    sync_b        = SYNC_SECOND_RST;
    scale         = FULL_SCALE_RST;
    bar_full      = BAR_FULL_RST;
    last_mv       = LAST_GOOD_RST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: first reading, repeat with doubled first sync,
    // full scale after noise, top of range, bad checksum
    send_frame('0, 1'b0, 0);
    send_frame('0, 1'b0, 1);
    send_word(8'h00);
    send_word(8'hFF);
    send_frame(FULL_SCALE_RST, 1'b0, 0);
    send_frame('1, 1'b0, 0);
    send_frame(16'h0102, 1'b1, 0);
    wait_idle();

    // sync register changed between value and checksum words
    send_word(sync_a);
    send_word(sync_b);
    send_word(8'h01);
    send_word(8'h00);
    wait_idle();
    set_reg(CFG_SYNC_FIRST, 16'hAB12);
    set_reg(CFG_BAR_FULL + 1'b1, 16'hFFFF);
    cfg_we <= 1'b0;
    @(negedge clk);
    sync_a = 8'h12;
    send_word(sync_a ^ sync_b ^ 8'h01 ^ 8'h00);
    wait_idle();

    program_regs(8'h00, 8'hFF, 16'hFFFF, 7'd127);
    run_phase(PHASE_WORDS);
    wait_idle();

    // zero full scale with equal sync words
    program_regs(8'h3C, 8'h3C, 16'h0000, 7'd127);
    run_phase(PHASE_WORDS);
    wait_idle();

    program_regs(8'hFF, 8'h00, 16'h0001, 7'd0);
    hold_req = 1'b1;
    run_phase(PHASE_WORDS);
    wait_idle();

    repeat (RANDOM_PHASES) begin
      sa = BYTE_W'($urandom);
      sb = ($urandom_range(0, 3) == 0) ? sa : BYTE_W'($urandom);
      case ($urandom_range(0, 5))
        0:       fs = '0;
        1:       fs = '1;
        2:       fs = 16'd1;
        3:       fs = FULL_SCALE_RST;
        default: fs = MV_W'($urandom);
      endcase
      program_regs(sa, sb, fs, BAR_W'($urandom_range(0, 127)));
      run_phase(PHASE_WORDS);
      wait_idle();
    end

    calm = 1'b1;
    program_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, FULL_SCALE_RST, BAR_FULL_RST);
    run_phase(PHASE_WORDS);
    wait_idle();

    if (mismatches == 0 && pending == 0) begin
      $display("sync_framed_reading_receiver_top_tb OK");
    end else begin
      $display("sync_framed_reading_receiver_top_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sfrr_pkg.sv
hdl/sfrr_in_if.sv
hdl/sfrr_out_if.sv
hdl/sfrr_ctrl.sv
hdl/sfrr_datapath.sv
hdl/sync_framed_reading_receiver_top.sv
verif/sfrr_reading_checker.sv
verif/sync_framed_reading_receiver_top_tb.sv
